// ===== design/ttcw_pkg.sv =====
// ----------------------------------------------------------------------------
// ttcw_pkg
// Shared widths, character and color codes, sequencer states and the
// command structs of the character-cell terminal.
// ----------------------------------------------------------------------------
`default_nettype none

package ttcw_pkg;

    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;
    localparam int CHAR_W  = 8;
    localparam int COLOR_W = 32;

    localparam logic [CHAR_W-1:0]  CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0]  CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0]  CH_SPACE     = 8'd32;
    localparam logic [COLOR_W-1:0] COLOR_WHITE  = 32'hFFFF_FFFF;
    localparam logic [COLOR_W-1:0] COLOR_BLACK  = 32'h0000_00FF;

    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_ADDR,
        ST_ACCESS,
        ST_RDATA,
        ST_DONE
    } state_t;

    // logical cell position handed to the address unit
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } cell_pos_t;

    typedef struct packed {
        logic                rd_en;
        logic                wr_char;
        logic                wr_color;
        logic [CHAR_W-1:0]   wdata_char;
        logic [COLOR_W-1:0]  wdata_color;
    } mem_cmd_t;

endpackage

`default_nettype wire

// ===== design/ttcw_if.sv =====
// ----------------------------------------------------------------------------
// ttcw_if
// Valid/ready channels of the terminal: request channel and response channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface ttcw_req_if;
    logic                            valid;
    logic                            ready;
    logic                            operation;
    logic [ttcw_pkg::CHAR_W-1:0]     char_code;
    logic [ttcw_pkg::COLOR_W-1:0]    char_color;
    logic [ttcw_pkg::COL_W-1:0]      read_col;
    logic [ttcw_pkg::ROW_W-1:0]      read_row;

    modport source (output valid, operation, char_code, char_color, read_col, read_row,
                    input ready);
    modport sink   (input valid, operation, char_code, char_color, read_col, read_row,
                    output ready);
endinterface

interface ttcw_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [ttcw_pkg::CHAR_W-1:0]     cell_char;
    logic [ttcw_pkg::COLOR_W-1:0]    cell_color;
    logic [ttcw_pkg::COL_W-1:0]      cursor_col;
    logic [ttcw_pkg::ROW_W-1:0]      cursor_row;

    modport source (output valid, cell_char, cell_color, cursor_col, cursor_row,
                    input ready);
    modport sink   (input valid, cell_char, cell_color, cursor_col, cursor_row,
                    output ready);
endinterface

`default_nettype wire

// ===== design/ttcw_addr.sv =====
// ----------------------------------------------------------------------------
// ttcw_addr
// Shared address unit: maps a logical (row, col) onto the circular row
// store, phys = ((top + row) mod ROWS) * COLUMNS + col. The address is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ttcw_addr #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25,
    parameter int ADDR_W  = 11
) (
    input  logic                        clk,
    input  logic [ttcw_pkg::ROW_W-1:0]  top,
    input  ttcw_pkg::cell_pos_t         pos,
    output logic [ADDR_W-1:0]           addr_reg
);

    localparam int SUM_W  = ttcw_pkg::ROW_W + 1;
    localparam int PROD_W = SUM_W + ttcw_pkg::COL_W + 1;

    logic [SUM_W-1:0]  row_sum;
    logic [SUM_W-1:0]  phys_row;
    logic [PROD_W-1:0] row_base;
    logic [ADDR_W-1:0] addr_next;

    always_comb
    begin
        row_sum  = {1'b0, top} + {1'b0, pos.row};
        phys_row = (row_sum >= SUM_W'(ROWS)) ? row_sum - SUM_W'(ROWS) : row_sum;
        row_base = PROD_W'(phys_row) * PROD_W'(COLUMNS);
        addr_next = ADDR_W'(row_base + PROD_W'(pos.col));
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
    end

endmodule

`default_nettype wire

// ===== design/ttcw_mem.sv =====
// ----------------------------------------------------------------------------
// ttcw_mem
// Cell store: separate character and color arrays sharing one address, so
// a backspace can blank the character and leave the color. Registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ttcw_mem #(
    parameter int DEPTH  = 2000,
    parameter int ADDR_W = 11
) (
    input  logic                           clk,
    input  logic [ADDR_W-1:0]              addr,
    input  ttcw_pkg::mem_cmd_t             cmd,
    output logic [ttcw_pkg::CHAR_W-1:0]    rd_char_reg,
    output logic [ttcw_pkg::COLOR_W-1:0]   rd_color_reg
);

    logic [ttcw_pkg::CHAR_W-1:0]  char_mem  [DEPTH];
    logic [ttcw_pkg::COLOR_W-1:0] color_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (cmd.wr_char)
        begin
            char_mem[addr] <= cmd.wdata_char;
        end
        if (cmd.wr_color)
        begin
            color_mem[addr] <= cmd.wdata_color;
        end
        if (cmd.rd_en)
        begin
            rd_char_reg  <= char_mem[addr];
            rd_color_reg <= color_mem[addr];
        end
    end

endmodule

`default_nettype wire

// ===== design/ttcw_ctrl.sv =====
// ----------------------------------------------------------------------------
// ttcw_ctrl
// Sequencer: takes requests, keeps the cursor and the top-row pointer,
// drives the address unit and the cell store, runs the row sweeps for the
// reset clear and for scrolling, and holds the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module ttcw_ctrl #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                           clk,
    input  logic                           rst_n,
    ttcw_req_if.sink                       req,
    ttcw_rsp_if.source                     rsp,
    output logic [ttcw_pkg::ROW_W-1:0]     top_reg,
    output ttcw_pkg::cell_pos_t            pos,
    output ttcw_pkg::mem_cmd_t             mem_cmd,
    input  logic [ttcw_pkg::CHAR_W-1:0]    rd_char,
    input  logic [ttcw_pkg::COLOR_W-1:0]   rd_color
);

    localparam int COL_W   = ttcw_pkg::COL_W;
    localparam int ROW_W   = ttcw_pkg::ROW_W;
    localparam int CHAR_W  = ttcw_pkg::CHAR_W;
    localparam int COLOR_W = ttcw_pkg::COLOR_W;

    localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
    localparam logic [COL_W:0]   COLS_X   = (COL_W + 1)'(COLUMNS);
    localparam logic [ROW_W:0]   ROWS_X   = (ROW_W + 1)'(ROWS);

    ttcw_pkg::state_t state_reg, state_next;

    // control
    logic [COL_W-1:0]    cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]    cur_row_reg, cur_row_next;
    logic [ROW_W-1:0]    top_next;
    logic [COL_W-1:0]    sw_col_reg, sw_col_next;
    logic [ROW_W-1:0]    sw_row_reg, sw_row_next;
    logic [ROW_W-1:0]    sw_end_reg, sw_end_next;
    logic [COLOR_W-1:0]  sw_fill_reg, sw_fill_next;
    logic                sw_fed_reg, sw_fed_next;
    logic                sw_wr_reg, sw_wr_next;
    logic                sw_scroll_reg, sw_scroll_next;
    logic                rsp_valid_reg, rsp_valid_next;

    // payload
    logic                op_reg, op_next;
    logic [CHAR_W-1:0]   code_reg, code_next;
    logic [COLOR_W-1:0]  color_reg, color_next;
    logic [COL_W-1:0]    rcol_reg, rcol_next;
    logic [ROW_W-1:0]    rrow_reg, rrow_next;
    logic [CHAR_W-1:0]   res_char_reg, res_char_next;
    logic [COLOR_W-1:0]  res_color_reg, res_color_next;
    logic [CHAR_W-1:0]   out_char_reg, out_char_next;
    logic [COLOR_W-1:0]  out_color_reg, out_color_next;
    logic [COL_W-1:0]    out_col_reg, out_col_next;
    logic [ROW_W-1:0]    out_row_reg, out_row_next;

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.cell_char  = out_char_reg;
    assign rsp.cell_color = out_color_reg;
    assign rsp.cursor_col = out_col_reg;
    assign rsp.cursor_row = out_row_reg;
    assign req.ready      = (state_reg == ttcw_pkg::ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ttcw_pkg::ST_SWEEP;
            cur_col_reg   <= '0;
            cur_row_reg   <= '0;
            top_reg       <= '0;
            sw_col_reg    <= '0;
            sw_row_reg    <= '0;
            sw_end_reg    <= ROW_LAST;
            sw_fill_reg   <= ttcw_pkg::COLOR_BLACK;
            sw_fed_reg    <= 1'b0;
            sw_wr_reg     <= 1'b0;
            sw_scroll_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_col_reg   <= cur_col_next;
            cur_row_reg   <= cur_row_next;
            top_reg       <= top_next;
            sw_col_reg    <= sw_col_next;
            sw_row_reg    <= sw_row_next;
            sw_end_reg    <= sw_end_next;
            sw_fill_reg   <= sw_fill_next;
            sw_fed_reg    <= sw_fed_next;
            sw_wr_reg     <= sw_wr_next;
            sw_scroll_reg <= sw_scroll_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        code_reg      <= code_next;
        color_reg     <= color_next;
        rcol_reg      <= rcol_next;
        rrow_reg      <= rrow_next;
        res_char_reg  <= res_char_next;
        res_color_reg <= res_color_next;
        out_char_reg  <= out_char_next;
        out_color_reg <= out_color_next;
        out_col_reg   <= out_col_next;
        out_row_reg   <= out_row_next;
    end

    always_comb
    begin
        logic adv_row;

        adv_row        = 1'b0;
        state_next     = state_reg;
        cur_col_next   = cur_col_reg;
        cur_row_next   = cur_row_reg;
        top_next       = top_reg;
        sw_col_next    = sw_col_reg;
        sw_row_next    = sw_row_reg;
        sw_end_next    = sw_end_reg;
        sw_fill_next   = sw_fill_reg;
        sw_fed_next    = sw_fed_reg;
        sw_wr_next     = sw_wr_reg;
        sw_scroll_next = sw_scroll_reg;
        rsp_valid_next = rsp_valid_reg;
        op_next        = op_reg;
        code_next      = code_reg;
        color_next     = color_reg;
        rcol_next      = rcol_reg;
        rrow_next      = rrow_reg;
        res_char_next  = res_char_reg;
        res_color_next = res_color_reg;
        out_char_next  = out_char_reg;
        out_color_next = out_color_reg;
        out_col_next   = out_col_reg;
        out_row_next   = out_row_reg;

        pos                 = '{row: cur_row_reg, col: cur_col_reg};
        mem_cmd.rd_en       = 1'b0;
        mem_cmd.wr_char     = 1'b0;
        mem_cmd.wr_color    = 1'b0;
        mem_cmd.wdata_char  = ttcw_pkg::CH_SPACE;
        mem_cmd.wdata_color = sw_fill_reg;

        if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ttcw_pkg::ST_SWEEP:
            begin
                // address fed one cycle, written the next
                pos              = '{row: sw_row_reg, col: sw_col_reg};
                mem_cmd.wr_char  = sw_wr_reg;
                mem_cmd.wr_color = sw_wr_reg;
                if (!sw_fed_reg)
                begin
                    sw_wr_next = 1'b1;
                    if (sw_col_reg == COL_LAST)
                    begin
                        sw_col_next = '0;
                        if (sw_row_reg == sw_end_reg)
                        begin
                            sw_fed_next = 1'b1;
                        end
                        else
                        begin
                            sw_row_next = sw_row_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        sw_col_next = sw_col_reg + 1'b1;
                    end
                end
                else
                begin
                    sw_wr_next = 1'b0;
                    if (sw_scroll_reg)
                    begin
                        // old top row now holds the blank bottom row
                        top_next   = (top_reg == ROW_LAST) ? '0 : top_reg + 1'b1;
                        state_next = ttcw_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = ttcw_pkg::ST_IDLE;
                    end
                end
            end

            ttcw_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    op_next    = req.operation;
                    code_next  = req.char_code;
                    color_next = req.char_color;
                    rcol_next  = req.read_col;
                    rrow_next  = req.read_row;
                    state_next = ttcw_pkg::ST_ADDR;
                end
            end

            ttcw_pkg::ST_ADDR:
            begin
                if (op_reg == ttcw_pkg::OP_READ)
                begin
                    pos = '{row: rrow_reg, col: rcol_reg};
                end
                else if (code_reg == ttcw_pkg::CH_BACKSPACE)
                begin
                    if (cur_col_reg == '0)
                    begin
                        pos = '{row: cur_row_reg - 1'b1, col: COL_LAST};
                    end
                    else
                    begin
                        pos = '{row: cur_row_reg, col: cur_col_reg - 1'b1};
                    end
                end
                state_next = ttcw_pkg::ST_ACCESS;
            end

            ttcw_pkg::ST_ACCESS:
            begin
                res_char_next  = '0;
                res_color_next = '0;
                state_next     = ttcw_pkg::ST_DONE;
                if (op_reg == ttcw_pkg::OP_READ)
                begin
                    if ({1'b0, rcol_reg} < COLS_X && {1'b0, rrow_reg} < ROWS_X)
                    begin
                        mem_cmd.rd_en = 1'b1;
                        state_next    = ttcw_pkg::ST_RDATA;
                    end
                end
                else
                begin
                    case (code_reg)
                        ttcw_pkg::CH_NEWLINE:
                        begin
                            cur_col_next = '0;
                            adv_row      = 1'b1;
                        end
                        ttcw_pkg::CH_BACKSPACE:
                        begin
                            // at the origin nothing changes
                            if (cur_col_reg != '0 || cur_row_reg != '0)
                            begin
                                mem_cmd.wr_char    = 1'b1;
                                mem_cmd.wdata_char = ttcw_pkg::CH_SPACE;
                                if (cur_col_reg == '0)
                                begin
                                    cur_col_next = COL_LAST;
                                    cur_row_next = cur_row_reg - 1'b1;
                                end
                                else
                                begin
                                    cur_col_next = cur_col_reg - 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            mem_cmd.wr_char     = 1'b1;
                            mem_cmd.wr_color    = 1'b1;
                            mem_cmd.wdata_char  = code_reg;
                            mem_cmd.wdata_color = color_reg;
                            if (cur_col_reg == COL_LAST)
                            begin
                                cur_col_next = '0;
                                adv_row      = 1'b1;
                            end
                            else
                            begin
                                cur_col_next = cur_col_reg + 1'b1;
                            end
                        end
                    endcase
                    if (adv_row)
                    begin
                        if (cur_row_reg == ROW_LAST)
                        begin
                            // scroll: blank logical row 0, then move top down
                            sw_col_next    = '0;
                            sw_row_next    = '0;
                            sw_end_next    = '0;
                            sw_fill_next   = ttcw_pkg::COLOR_WHITE;
                            sw_fed_next    = 1'b0;
                            sw_wr_next     = 1'b0;
                            sw_scroll_next = 1'b1;
                            state_next     = ttcw_pkg::ST_SWEEP;
                        end
                        else
                        begin
                            cur_row_next = cur_row_reg + 1'b1;
                        end
                    end
                end
            end

            ttcw_pkg::ST_RDATA:
            begin
                res_char_next  = rd_char;
                res_color_next = rd_color;
                state_next     = ttcw_pkg::ST_DONE;
            end

            ttcw_pkg::ST_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    out_char_next  = res_char_reg;
                    out_color_next = res_color_reg;
                    out_col_next   = cur_col_reg;
                    out_row_next   = cur_row_reg;
                    state_next     = ttcw_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = ttcw_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/text_terminal_cell_writer.sv =====
// ----------------------------------------------------------------------------
// text_terminal_cell_writer
// Character-cell text terminal: put characters at a cursor with newline,
// backspace, wrap and scroll; read cells back for display.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                          | handshake
//  req     | in  | operation, char_code, char_color, read_col/row   | valid/ready
//  rsp     | out | cell_char, cell_color, cursor_col, cursor_row    | valid/ready
//
//  A put passes ST_ADDR, ST_ACCESS and ST_DONE after accept; a read of an
//  on-screen cell also passes ST_RDATA. A put that scrolls first sweeps one
//  row blank; rows live in a circular store under a top-row pointer.
//  After reset the cell store is swept once with req.ready low. A response
//  left waiting on rsp does not block the next request; that request
//  stalls only at its own response.
// ----------------------------------------------------------------------------
`default_nettype none

module text_terminal_cell_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        clk,
    input  logic        rst_n,
    ttcw_req_if.sink    req,
    ttcw_rsp_if.source  rsp
);

    localparam int DEPTH  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [ttcw_pkg::ROW_W-1:0]   top_row;
    ttcw_pkg::cell_pos_t          pos;
    ttcw_pkg::mem_cmd_t           mem_cmd;
    logic [ADDR_W-1:0]            addr;
    logic [ttcw_pkg::CHAR_W-1:0]  rd_char;
    logic [ttcw_pkg::COLOR_W-1:0] rd_color;

    ttcw_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .rsp      (rsp),
        .top_reg  (top_row),
        .pos      (pos),
        .mem_cmd  (mem_cmd),
        .rd_char  (rd_char),
        .rd_color (rd_color)
    );

    ttcw_addr #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .ADDR_W  (ADDR_W)
    ) u_addr (
        .clk      (clk),
        .top      (top_row),
        .pos      (pos),
        .addr_reg (addr)
    );

    ttcw_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk          (clk),
        .addr         (addr),
        .cmd          (mem_cmd),
        .rd_char_reg  (rd_char),
        .rd_color_reg (rd_color)
    );

    // store is quiet whenever the block waits for a request
    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> !(mem_cmd.wr_char || mem_cmd.wr_color))
        else $error("cell store written while idle");

    // a color write always comes with a character write
    a_color_with_char: assert property (@(posedge clk) disable iff (!rst_n)
        mem_cmd.wr_color |-> mem_cmd.wr_char)
        else $error("color written without character");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request taken while previous one in flight");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.cursor_col < COLUMNS && rsp.cursor_row < ROWS))
        else $error("cursor outside screen");

    a_top_range: assert property (@(posedge clk) disable iff (!rst_n)
        top_row < ROWS)
        else $error("top row pointer out of range");

endmodule

`default_nettype wire
